/* design/clp_pkg.sv */
// Shared types, constants and arithmetic helpers of the D2Q9 BGK collision pipeline.
package clp_pkg;

    localparam int QF     = 28;
    localparam int NDIR   = 9;
    localparam int NSTEP  = 33;

    // Direction order: rest, E, N, W, S, NE, NW, SW, SE
    localparam int OPP    [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    localparam int WCLASS [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

    typedef logic signed [31:0] q_t;
    typedef logic [NDIR-1:0][31:0] dist_vec_t;

    typedef enum logic [1:0] {
        REG_RELAX  = 2'd0,
        REG_W_REST = 2'd1,
        REG_W_AXIS = 2'd2,
        REG_W_DIAG = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [29:0] relax;
        logic [28:0] w_rest;
        logic [28:0] w_axis;
        logic [28:0] w_diag;
    } cfg_t;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [30:0] rem;
        logic [32:0] quo;
        logic [31:0] mag;
    } div_lane_t;

    typedef struct packed {
        q_t        vel_y;
        q_t        vel_x;
        dist_vec_t new_dist;
    } result_t;

    // Clamp a wide signed value to 32 bits
    function automatic q_t sat32(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Scale a raw Q4.28 product back, rounding toward minus infinity
    function automatic q_t q_round(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> QF;
        return sat32(s);
    endfunction

    // Set up one divider lane: magnitude, sign and quotient overflow check
    function automatic div_lane_t div_prep(input q_t m, input logic [30:0] d);
        div_lane_t  l;
        logic [32:0] negm;
        negm   = -33'(m);
        l.neg  = m[31];
        l.mag  = m[31] ? negm[31:0] : m;
        l.ovf  = ({4'b0, l.mag[31:5]} >= d);
        l.rem  = {4'b0, l.mag[31:5]};
        l.quo  = '0;
        return l;
    endfunction

    // One restoring division step: bring in one numerator bit
    function automatic div_lane_t div_step(input div_lane_t l, input logic [30:0] d,
                                           input logic b);
        div_lane_t  r;
        logic [31:0] t;
        logic [31:0] diff;
        r    = l;
        t    = {l.rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            r.rem = diff[30:0];
            r.quo = {l.quo[31:0], 1'b1};
        end else begin
            r.rem = t[30:0];
            r.quo = {l.quo[31:0], 1'b0};
        end
        return r;
    endfunction

    // Apply sign and saturation to the quotient, or return zero for nonpositive density
    function automatic q_t div_finish(input div_lane_t l, input logic pos);
        q_t          r;
        logic [32:0] negq;
        negq = -l.quo;
        if (!pos) begin
            r = '0;
        end else if (l.neg) begin
            r = (l.ovf || l.quo > 33'h080000000) ? 32'sh80000000 : negq[31:0];
        end else begin
            r = (l.ovf || l.quo > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : l.quo[31:0];
        end
        return r;
    endfunction

endpackage

/* design/clp_front.sv */
// Input stage: bounce-back swap, density and momentum sums.
module clp_front import clp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  dist_vec_t in_dist,
    input  logic      in_fluid,
    output logic      out_valid,
    output dist_vec_t out_dist,
    output q_t        out_rho,
    output q_t        out_mx,
    output q_t        out_my
);

    logic      valid_reg;
    dist_vec_t dist_reg, dist_next;
    q_t        rho_reg, rho_next;
    q_t        mx_reg, mx_next;
    q_t        my_reg, my_next;

    // Swap moving directions for wall cells, then sum
    always_comb begin
        logic signed [35:0] rs;
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        for (int i = 0; i < NDIR; i++) begin
            dist_next[i] = in_fluid ? in_dist[i] : in_dist[OPP[i]];
        end
        rs = '0;
        for (int i = 0; i < NDIR; i++) begin
            rs = rs + 36'($signed(dist_next[i]));
        end
        xs = 36'($signed(dist_next[1])) - 36'($signed(dist_next[3]))
           + 36'($signed(dist_next[5])) - 36'($signed(dist_next[6]))
           - 36'($signed(dist_next[7])) + 36'($signed(dist_next[8]));
        ys = 36'($signed(dist_next[2])) - 36'($signed(dist_next[4]))
           + 36'($signed(dist_next[5])) + 36'($signed(dist_next[6]))
           - 36'($signed(dist_next[7])) - 36'($signed(dist_next[8]));
        rho_next = sat32(64'(rs));
        mx_next  = sat32(64'(xs));
        my_next  = sat32(64'(ys));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
            rho_reg  <= rho_next;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_dist  = dist_reg;
    assign out_rho   = rho_reg;
    assign out_mx    = mx_reg;
    assign out_my    = my_reg;

endmodule

/* design/clp_div.sv */
// Pipelined restoring divider for both velocity components, one quotient bit per stage.
module clp_div import clp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  dist_vec_t in_dist,
    input  q_t        in_rho,
    input  q_t        in_mx,
    input  q_t        in_my,
    output logic      out_valid,
    output dist_vec_t out_dist,
    output q_t        out_rho,
    output q_t        out_vx,
    output q_t        out_vy
);

    logic      valid_reg [NSTEP+1];
    div_lane_t lx_reg    [NSTEP+1];
    div_lane_t ly_reg    [NSTEP+1];
    dist_vec_t dist_reg  [NSTEP+1];
    q_t        rho_reg   [NSTEP+1];

    logic      fin_valid_reg;
    dist_vec_t fin_dist_reg;
    q_t        fin_rho_reg;
    q_t        vx_reg, vx_next;
    q_t        vy_reg, vy_next;
    logic      pos;

    // Prepare magnitudes and overflow flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lx_reg[0]   <= div_prep(in_mx, in_rho[30:0]);
            ly_reg[0]   <= div_prep(in_my, in_rho[30:0]);
            dist_reg[0] <= in_dist;
            rho_reg[0]  <= in_rho;
        end
    end

    // Advance one quotient bit per stage, most significant first
    for (genvar g = 1; g <= NSTEP; g++) begin : g_step
        localparam int K = NSTEP - g;
        logic bx, by;
        if (K >= QF) begin : g_bit
            assign bx = lx_reg[g-1].mag[K-QF];
            assign by = ly_reg[g-1].mag[K-QF];
        end else begin : g_zero
            assign bx = 1'b0;
            assign by = 1'b0;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= valid_reg[g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lx_reg[g]   <= div_step(lx_reg[g-1], rho_reg[g-1][30:0], bx);
                ly_reg[g]   <= div_step(ly_reg[g-1], rho_reg[g-1][30:0], by);
                dist_reg[g] <= dist_reg[g-1];
                rho_reg[g]  <= rho_reg[g-1];
            end
        end
    end

    // Sign, saturate, and zero for nonpositive density
    assign pos     = !rho_reg[NSTEP][31] && (rho_reg[NSTEP] != '0);
    assign vx_next = div_finish(lx_reg[NSTEP], pos);
    assign vy_next = div_finish(ly_reg[NSTEP], pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= valid_reg[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg       <= vx_next;
            vy_reg       <= vy_next;
            fin_dist_reg <= dist_reg[NSTEP];
            fin_rho_reg  <= rho_reg[NSTEP];
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_dist  = fin_dist_reg;
    assign out_rho   = fin_rho_reg;
    assign out_vx    = vx_reg;
    assign out_vy    = vy_reg;

endmodule

/* design/clp_eq.sv */
// Equilibrium and relaxation pipeline: at most one multiplier level per stage.
module clp_eq import clp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  cfg_t      cfg,
    input  logic      in_valid,
    input  dist_vec_t in_dist,
    input  q_t        in_rho,
    input  q_t        in_vx,
    input  q_t        in_vy,
    output logic      out_valid,
    output result_t   out_res
);

    logic [7:1] valid_reg;

    // Carried fields
    dist_vec_t dist1_reg, dist2_reg, dist3_reg, dist4_reg, dist5_reg, dist6_reg;
    q_t        vx1_reg, vx2_reg, vx3_reg, vx4_reg, vx5_reg, vx6_reg, vx7_reg;
    q_t        vy1_reg, vy2_reg, vy3_reg, vy4_reg, vy5_reg, vy6_reg, vy7_reg;

    // Stage 1: squares, density times weight, projections
    logic signed [63:0] pvx1_reg, pvy1_reg;
    logic signed [63:0] prw1_reg [3];
    q_t                 e1_reg   [NDIR];
    // Stage 2: usq, scaled weights, projection squares
    q_t                 usq2_reg;
    q_t                 rwq2_reg [3];
    q_t                 e2_reg   [NDIR];
    logic signed [63:0] pee2_reg [NDIR];
    // Stage 3: polynomials
    q_t                 rwq3_reg [3];
    q_t                 poly3_reg [NDIR];
    // Stage 4: raw equilibria
    logic signed [63:0] pfeq4_reg [NDIR];
    // Stage 5: distance to equilibrium
    logic signed [32:0] diff5_reg [NDIR];
    // Stage 6: raw relaxation
    logic signed [63:0] prel6_reg [NDIR];
    // Stage 7: result
    dist_vec_t          new7_reg, new7_next;

    q_t        e_next [NDIR];
    q_t        usq_next;
    q_t        poly_next [NDIR];

    // Project velocity onto each direction
    always_comb begin
        logic signed [33:0] x;
        logic signed [33:0] y;
        x = 34'(in_vx);
        y = 34'(in_vy);
        e_next[0] = '0;
        e_next[1] = sat32(64'(x));
        e_next[2] = sat32(64'(y));
        e_next[3] = sat32(64'(-x));
        e_next[4] = sat32(64'(-y));
        e_next[5] = sat32(64'(x + y));
        e_next[6] = sat32(64'(y - x));
        e_next[7] = sat32(64'(-x - y));
        e_next[8] = sat32(64'(x - y));
    end

    // Squared speed term 1.5 * (vx^2 + vy^2)
    always_comb begin
        logic signed [39:0] s;
        logic signed [39:0] u;
        s = 40'(q_round(pvx1_reg)) + 40'(q_round(pvy1_reg));
        u = (s * 40'sd3) >>> 1;
        usq_next = sat32(64'(u));
    end

    // Polynomial 1 + 3e + 4.5e^2 - usq
    always_comb begin
        logic signed [39:0] t;
        logic signed [39:0] h;
        for (int i = 0; i < NDIR; i++) begin
            h = (40'(q_round(pee2_reg[i])) * 40'sd9) >>> 1;
            t = 40'sd268435456 + 40'(e2_reg[i]) * 40'sd3 + h - 40'(usq2_reg);
            poly_next[i] = sat32(64'(t));
        end
    end

    // Add the relaxation step back onto the distribution
    always_comb begin
        logic signed [32:0] t;
        for (int i = 0; i < NDIR; i++) begin
            t = 33'($signed(dist6_reg[i])) + 33'(q_round(prel6_reg[i]));
            new7_next[i] = sat32(64'(t));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1
            pvx1_reg    <= in_vx * in_vx;
            pvy1_reg    <= in_vy * in_vy;
            prw1_reg[0] <= in_rho * $signed({1'b0, cfg.w_rest});
            prw1_reg[1] <= in_rho * $signed({1'b0, cfg.w_axis});
            prw1_reg[2] <= in_rho * $signed({1'b0, cfg.w_diag});
            e1_reg      <= e_next;
            dist1_reg   <= in_dist;
            vx1_reg     <= in_vx;
            vy1_reg     <= in_vy;
            // stage 2
            usq2_reg    <= usq_next;
            for (int k = 0; k < 3; k++) begin
                rwq2_reg[k] <= q_round(prw1_reg[k]);
            end
            for (int i = 0; i < NDIR; i++) begin
                pee2_reg[i] <= e1_reg[i] * e1_reg[i];
            end
            e2_reg      <= e1_reg;
            dist2_reg   <= dist1_reg;
            vx2_reg     <= vx1_reg;
            vy2_reg     <= vy1_reg;
            // stage 3
            rwq3_reg    <= rwq2_reg;
            poly3_reg   <= poly_next;
            dist3_reg   <= dist2_reg;
            vx3_reg     <= vx2_reg;
            vy3_reg     <= vy2_reg;
            // stage 4
            for (int i = 0; i < NDIR; i++) begin
                pfeq4_reg[i] <= rwq3_reg[WCLASS[i]] * poly3_reg[i];
            end
            dist4_reg   <= dist3_reg;
            vx4_reg     <= vx3_reg;
            vy4_reg     <= vy3_reg;
            // stage 5
            for (int i = 0; i < NDIR; i++) begin
                diff5_reg[i] <= 33'(q_round(pfeq4_reg[i])) - 33'($signed(dist4_reg[i]));
            end
            dist5_reg   <= dist4_reg;
            vx5_reg     <= vx4_reg;
            vy5_reg     <= vy4_reg;
            // stage 6
            for (int i = 0; i < NDIR; i++) begin
                prel6_reg[i] <= $signed({1'b0, cfg.relax}) * diff5_reg[i];
            end
            dist6_reg   <= dist5_reg;
            vx6_reg     <= vx5_reg;
            vy6_reg     <= vy5_reg;
            // stage 7
            new7_reg    <= new7_next;
            vx7_reg     <= vx6_reg;
            vy7_reg     <= vy6_reg;
        end
    end

    assign out_valid        = valid_reg[7];
    assign out_res.new_dist = new7_reg;
    assign out_res.vel_x    = vx7_reg;
    assign out_res.vel_y    = vy7_reg;

endmodule

/* design/clp_skid.sv */
// Output register with a skid entry so the pipeline ready is registered.
module clp_skid import clp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take = in_valid && !skid_valid_reg;

    // Refill the output from the skid entry first, else park a stalled request
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take;
                out_data_next  = in_data;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/d2q9_bgk_cell_collision_top.sv */
// Top level of the D2Q9 BGK lattice cell collision pipeline.
// Takes one cell per clock while s_tready is high and returns one result per cell,
// in order. The path runs through 1 sum stage, 35 divider stages (33 one-bit
// restoring division steps plus setup and sign/saturate), 7 equilibrium and
// relaxation stages, and the output register. The divider chain sets the latency.
// s_tready drops only while a result waits in the skid entry behind a stalled
// output. The user must write the configuration registers only while the
// pipeline is empty; the block itself does not enforce this.
module d2q9_bgk_cell_collision_top import clp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // dist_rest, dist_east, dist_north, dist_west, dist_south,
    // dist_northeast, dist_northwest, dist_southwest, dist_southeast (32 bits each)
    input  logic [287:0] s_tdata,
    input  logic [0:0]   s_tuser,   // fluid_mark
    input  logic         s_tvalid,
    output logic         s_tready,
    // new_rest, new_east, new_north, new_west, new_south, new_northeast,
    // new_northwest, new_southwest, new_southeast, velocity_x, velocity_y (32 bits each)
    output logic [351:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [29:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      en;

    logic      fr_valid;
    dist_vec_t fr_dist;
    q_t        fr_rho, fr_mx, fr_my;

    logic      dv_valid;
    dist_vec_t dv_dist;
    q_t        dv_rho, dv_vx, dv_vy;

    logic      eq_valid;
    result_t   eq_res;
    result_t   out_res;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.relax  <= 30'd526344031;
            cfg_reg.w_rest <= 29'd119304647;
            cfg_reg.w_axis <= 29'd29826162;
            cfg_reg.w_diag <= 29'd7456540;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_RELAX:  cfg_reg.relax  <= cfg_data;
                REG_W_REST: cfg_reg.w_rest <= cfg_data[28:0];
                REG_W_AXIS: cfg_reg.w_axis <= cfg_data[28:0];
                REG_W_DIAG: cfg_reg.w_diag <= cfg_data[28:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // Advance the whole pipeline while the skid entry is free
    assign s_tready = en;

    clp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_dist   (dist_vec_t'(s_tdata)),
        .in_fluid  (s_tuser[0]),
        .out_valid (fr_valid),
        .out_dist  (fr_dist),
        .out_rho   (fr_rho),
        .out_mx    (fr_mx),
        .out_my    (fr_my)
    );

    clp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_dist   (fr_dist),
        .in_rho    (fr_rho),
        .in_mx     (fr_mx),
        .in_my     (fr_my),
        .out_valid (dv_valid),
        .out_dist  (dv_dist),
        .out_rho   (dv_rho),
        .out_vx    (dv_vx),
        .out_vy    (dv_vy)
    );

    clp_eq u_eq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (dv_valid),
        .in_dist   (dv_dist),
        .in_rho    (dv_rho),
        .in_vx     (dv_vx),
        .in_vy     (dv_vy),
        .out_valid (eq_valid),
        .out_res   (eq_res)
    );

    clp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (eq_valid),
        .in_data   (eq_res),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res;

endmodule

/* design/clp_checker.sv */
// Port-level checks of the collision pipeline and their binding to the top level.
module clp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic [351:0] m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop input ready only behind a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input ready low without output stall");

    // Reopen input once the stalled result drains
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !s_tready |=> s_tready)
        else $error("input ready stuck after drain");

    // Leave reset empty and ready
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

bind d2q9_bgk_cell_collision_top clp_checker u_clp_checker (.*);
